[rtl/afu_pkg.sv]
// Package for the activation function unit: opcode encoding and the packed
// item types of the input and result channels. Depends on nothing else.
`timescale 1ns / 1ps

package afu_pkg;

    // Operation selected by each input item.
    typedef enum logic [2:0] {
        OP_IDENT = 3'd0,
        OP_DIDENT = 3'd1,
        OP_SIGM = 3'd2,
        OP_DSIGM = 3'd3,
        OP_TANH = 3'd4,
        OP_DTANH = 3'd5,
        OP_RELU = 3'd6,
        OP_DRELU = 3'd7
    } afu_op_t;

    // Input item: operation, fixed-point operand and end-of-vector marker.
    typedef struct packed {
        afu_op_t            opcode;
        logic signed [15:0] operand;
        logic               last_in;
    } afu_item_t;

    // Result item: clamped fixed-point value, clamp flag and marker copy.
    typedef struct packed {
        logic signed [15:0] result;
        logic               saturated;
        logic               last_out;
    } afu_res_t;

endpackage

[rtl/activation_function_unit_top.sv]
// Activation function unit, top level: two-stage pipeline with the sigmoid
// breakpoint table built at elaboration. Depends on afu_pkg.
`timescale 1ns / 1ps

// Usage
// The input channel (item_valid, item_ready, item) carries one item per
// handshake: an opcode, a signed fixed-point operand with FRAC_BITS fraction
// bits and a last marker. The result channel (res_valid, res_ready, res)
// returns exactly one item per input item, in order, with the clamped value,
// a saturation flag and the copied last marker.
// Throughput is one item per clock cycle while the receiver does not stall.
// An accepted item moves from the first register into the result register,
// which drives res_valid, as soon as that one has room. The first register
// holds the operand together with the sigmoid segment index and offset, the
// second register holds the finished result. Between them sits a table
// look-up and one shared multiplier, used for the interpolation, y*(1-y)
// or y*y.
// When the receiver stalls, the result register holds its item and the
// first stage keeps its item as well; item_ready falls only when both are
// full, so nothing is dropped and no gap opens when res_ready returns.
// Reset (rst_n low, asynchronous) empties both stages; the table is a set
// of constants and needs no initialisation time.
module activation_function_unit_top #(
    parameter int SEGMENTS = 32,
    parameter int FRAC_BITS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  afu_pkg::afu_item_t item,
    output logic               res_valid,
    input  logic               res_ready,
    output afu_pkg::afu_res_t  res
);

    // Width of the sigmoid argument, wide enough for twice the operand and
    // for the breakpoint range of plus and minus eight.
    localparam int XW = FRAC_BITS + 10;
    // Offset into the breakpoint span, and that offset times SEGMENTS.
    localparam int SW = FRAC_BITS + 4;
    localparam int UW = SW + 9;
    localparam int KW = $clog2(SEGMENTS);
    localparam int TABN = 2 ** KW;
    // Table entries lie in [0, one].
    localparam int TW = FRAC_BITS + 1;
    // Shared multiplier operand widths and product width.
    localparam int AW = FRAC_BITS + 8;
    localparam int BW = FRAC_BITS + 10;
    localparam int PW = AW + BW;
    // Width of the unclamped result.
    localparam int RW = 32;

    localparam logic [63:0] Q31_ONE = 64'd1 << 31;

    localparam logic signed [XW-1:0] EIGHT_X = XW'(longint'(8) << FRAC_BITS);
    localparam logic signed [BW-1:0] ONE_B = BW'(longint'(1) << FRAC_BITS);
    localparam logic signed [RW-1:0] ONE_R = RW'(longint'(1) << FRAC_BITS);
    localparam logic signed [PW-1:0] HALF_FX = PW'(longint'(1) << (FRAC_BITS - 1));
    localparam logic signed [PW-1:0] HALF_SPAN = PW'(longint'(1) << (SW - 1));
    localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
    localparam logic signed [RW-1:0] SAT_LO = -RW'(32768);

    function automatic logic [63:0] q31_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 30)) >> 31;
    endfunction

    // Quotient of two constants by restoring long division; it is only
    // evaluated at elaboration and builds no logic.
    function automatic logic [63:0] const_div(input logic [63:0] dividend,
                                              input logic [63:0] divisor);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], dividend[b]};
            if (rem >= 65'(divisor))
            begin
                rem = rem - 65'(divisor);
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Breakpoint k of the sigmoid, rounded to FRAC_BITS fraction bits. The
    // constant exp(-1/SEGMENTS) comes from a Taylor series in Q31 and is
    // raised to the needed power by repeated squaring.
    function automatic logic [63:0] sig_entry(input int k);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] g;
        logic [63:0] base;
        logic [63:0] acc;
        logic [63:0] ex;
        logic [63:0] den;
        logic [63:0] num;
        int          n;
        term = Q31_ONE;
        pos = Q31_ONE;
        neg = 64'd0;
        for (int i = 1; i < 64; i++)
        begin
            if (term != 64'd0)
            begin
                term = const_div(term, 64'(SEGMENTS) * 64'(i));
                if (i[0])
                begin
                    neg = neg + term;
                end
                else
                begin
                    pos = pos + term;
                end
            end
        end
        g = pos - neg;
        n = 16 * k - 8 * SEGMENTS;
        ex = (n < 0) ? 64'(-n) : 64'(n);
        acc = Q31_ONE;
        base = g;
        for (int j = 0; j < 16; j++)
        begin
            if (ex[0])
            begin
                acc = q31_mul(acc, base);
            end
            base = q31_mul(base, base);
            ex = ex >> 1;
        end
        den = Q31_ONE + acc;
        num = (n >= 0) ? (64'd1 << (FRAC_BITS + 31)) : (acc << FRAC_BITS);
        return const_div(num + den / 2, den);
    endfunction

    localparam logic [63:0] T_FIRST = sig_entry(0);
    localparam logic [63:0] T_LAST = sig_entry(SEGMENTS);

    // Per segment: the left breakpoint and the rise to the next one.
    logic [TW-1:0] tab_base [TABN];
    logic [TW-1:0] tab_diff [TABN];

    for (genvar k = 0; k < TABN; k++)
    begin : g_tab
        if (k < SEGMENTS)
        begin : g_used
            localparam logic [63:0] LO = sig_entry(k);
            localparam logic [63:0] HI = sig_entry(k + 1);
            assign tab_base[k] = TW'(LO);
            assign tab_diff[k] = TW'(HI - LO);
        end
        else
        begin : g_unused
            assign tab_base[k] = '0;
            assign tab_diff[k] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Handshake: each stage advances when the one after it has room.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic res_valid_reg;
    logic res_valid_next;
    logic s2_advance;
    logic s1_load;

    assign s2_advance = !res_valid_reg || res_ready;
    assign item_ready = !s1_valid_reg || s2_advance;
    assign s1_load = item_valid && item_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        res_valid_next = res_valid_reg;
        if (item_ready)
        begin
            s1_valid_next = item_valid;
        end
        if (s2_advance)
        begin
            res_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Input stage: locate the sigmoid argument within the breakpoints.
    // ------------------------------------------------------------------
    logic signed [XW-1:0] sig_arg;
    logic [SW-1:0]        span_ofs;
    logic [UW-1:0]        scaled_ofs;

    afu_pkg::afu_op_t     s1_op_reg;
    afu_pkg::afu_op_t     s1_op_next;
    logic signed [15:0]   s1_operand_reg;
    logic signed [15:0]   s1_operand_next;
    logic                 s1_last_reg;
    logic                 s1_last_next;
    logic                 s1_below_reg;
    logic                 s1_below_next;
    logic                 s1_above_reg;
    logic                 s1_above_next;
    logic [KW-1:0]        s1_seg_reg;
    logic [KW-1:0]        s1_seg_next;
    logic [SW-1:0]        s1_rem_reg;
    logic [SW-1:0]        s1_rem_next;

    always_comb
    begin
        // Tanh evaluates the sigmoid at twice its operand.
        if (item.opcode == afu_pkg::OP_TANH)
        begin
            sig_arg = XW'(item.operand) <<< 1;
        end
        else
        begin
            sig_arg = XW'(item.operand);
        end
        span_ofs = SW'(sig_arg + EIGHT_X);
        scaled_ofs = UW'(span_ofs) * UW'(SEGMENTS);

        s1_op_next = item.opcode;
        s1_operand_next = item.operand;
        s1_last_next = item.last_in;
        s1_below_next = sig_arg < -EIGHT_X;
        s1_above_next = sig_arg >= EIGHT_X;
        s1_seg_next = scaled_ofs[SW +: KW];
        s1_rem_next = scaled_ofs[SW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_op_reg <= s1_op_next;
            s1_operand_reg <= s1_operand_next;
            s1_last_reg <= s1_last_next;
            s1_below_reg <= s1_below_next;
            s1_above_reg <= s1_above_next;
            s1_seg_reg <= s1_seg_next;
            s1_rem_reg <= s1_rem_next;
        end
    end

    // ------------------------------------------------------------------
    // Result stage: table look-up, shared multiplier, rounding and clamp.
    // ------------------------------------------------------------------
    logic [TW-1:0]        seg_base;
    logic [TW-1:0]        seg_diff;
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] product;
    logic signed [PW-1:0] round_fx;
    logic signed [PW-1:0] round_sig;
    logic signed [RW-1:0] prod_fx;
    logic signed [RW-1:0] sig_val;
    logic signed [RW-1:0] operand_w;
    logic signed [RW-1:0] raw;
    afu_pkg::afu_res_t    res_reg;
    afu_pkg::afu_res_t    res_next;

    always_comb
    begin
        seg_base = tab_base[s1_seg_reg];
        seg_diff = tab_diff[s1_seg_reg];
        operand_w = RW'(s1_operand_reg);

        case (s1_op_reg)
            afu_pkg::OP_DSIGM:
            begin
                mul_a = AW'(s1_operand_reg);
                mul_b = ONE_B - BW'(s1_operand_reg);
            end
            afu_pkg::OP_DTANH:
            begin
                mul_a = AW'(s1_operand_reg);
                mul_b = BW'(s1_operand_reg);
            end
            default:
            begin
                mul_a = signed'(AW'(seg_diff));
                mul_b = signed'(BW'(s1_rem_reg));
            end
        endcase
        product = PW'(mul_a) * PW'(mul_b);

        // Round to nearest with ties upward, then drop the fraction bits.
        round_fx = (product + HALF_FX) >>> FRAC_BITS;
        round_sig = (product + HALF_SPAN) >>> SW;
        prod_fx = round_fx[RW-1:0];

        // Outside the breakpoints the sigmoid holds its end values.
        if (s1_below_reg)
        begin
            sig_val = signed'(RW'(T_FIRST));
        end
        else if (s1_above_reg)
        begin
            sig_val = signed'(RW'(T_LAST));
        end
        else
        begin
            sig_val = signed'(RW'(seg_base)) + round_sig[RW-1:0];
        end

        case (s1_op_reg)
            afu_pkg::OP_IDENT:  raw = operand_w;
            afu_pkg::OP_DIDENT: raw = ONE_R;
            afu_pkg::OP_SIGM:   raw = sig_val;
            afu_pkg::OP_DSIGM:  raw = prod_fx;
            afu_pkg::OP_TANH:   raw = (sig_val <<< 1) - ONE_R;
            afu_pkg::OP_DTANH:  raw = ONE_R - prod_fx;
            afu_pkg::OP_RELU:   raw = (operand_w > 0) ? operand_w : '0;
            afu_pkg::OP_DRELU:  raw = (operand_w > 0) ? ONE_R : '0;
            default:            raw = operand_w;
        endcase

        res_next.last_out = s1_last_reg;
        if (raw > SAT_HI)
        begin
            res_next.result = 16'sh7fff;
            res_next.saturated = 1'b1;
        end
        else if (raw < SAT_LO)
        begin
            res_next.result = 16'sh8000;
            res_next.saturated = 1'b1;
        end
        else
        begin
            res_next.result = raw[15:0];
            res_next.saturated = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

endmodule

[tb/tb_activation_function_unit_top.sv]
// Self-checking testbench for the activation function unit: drives the item
// channel, predicts every result in a scoreboard class and checks the result
// channel. Depends on afu_pkg and activation_function_unit_top.
`timescale 1ns / 1ps

module tb_activation_function_unit_top;

    import afu_pkg::*;

    localparam int SEGMENTS = 32;
    localparam int FRAC_BITS = 12;
    localparam longint ONE_Q = longint'(1) << FRAC_BITS;
    localparam longint HALF_Q = longint'(1) << (FRAC_BITS - 1);
    localparam longint unsigned Q31_ONE = 64'd1 << 31;
    localparam longint unsigned Q31_HALF = 64'd1 << 30;
    localparam int CLK_PERIOD = 12;
    // Cycles without any handshake on either channel before the run is
    // declared hung. The longest legitimate quiet stretch is the receiver
    // hold-off, so this leaves a wide margin.
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 80;

    // Scoreboard: keeps its own copy of the sigmoid breakpoint table, works
    // out the result of every accepted item and matches results in order.
    class activation_scoreboard;
        longint   sig_table[SEGMENTS + 1];
        afu_res_t pending_results[$];
        int       errors;

        // The breakpoints are round(2^FRAC_BITS * sigmoid(-8 + 16k/SEGMENTS)),
        // built in Q31 integer arithmetic: exp(-1/SEGMENTS) by a Taylor
        // series, then raised to the needed power by repeated squaring.
        function new();
            longint unsigned term, pos, neg, g, e, base, ex, d, num;
            longint n;
            errors = 0;
            term = Q31_ONE;
            pos = Q31_ONE;
            neg = 0;
            for (int k = 1; k < 64 && term != 0; k++)
            begin
                term = term / longint'(SEGMENTS * k);
                if (k % 2 == 1)
                    neg += term;
                else
                    pos += term;
            end
            g = pos - neg;
            for (int k = 0; k <= SEGMENTS; k++)
            begin
                n = 16 * k - 8 * SEGMENTS;
                ex = (n < 0) ? -n : n;
                e = Q31_ONE;
                base = g;
                while (ex != 0)
                begin
                    if (ex[0])
                        e = (e * base + Q31_HALF) >> 31;
                    base = (base * base + Q31_HALF) >> 31;
                    ex = ex >> 1;
                end
                d = Q31_ONE + e;
                num = (n >= 0) ? (64'd1 << (FRAC_BITS + 31)) : (e << FRAC_BITS);
                sig_table[k] = (num + d / 2) / d;
            end
        endfunction

        // Piecewise-linear sigmoid; the ends of the table are held outside
        // [-8, 8) without any saturation flag.
        function longint sigmoid_q(longint x);
            longint unsigned span, us, seg, offset, diff;
            span = 16 * ONE_Q;
            if (x < -8 * ONE_Q)
                return sig_table[0];
            if (x >= 8 * ONE_Q)
                return sig_table[SEGMENTS];
            us = x + 8 * ONE_Q;
            us = us * SEGMENTS;
            seg = us / span;
            offset = us % span;
            if (seg >= SEGMENTS)
                return sig_table[SEGMENTS];
            diff = sig_table[seg + 1] - sig_table[seg];
            return sig_table[seg] + longint'((diff * offset + span / 2) / span);
        endfunction

        function afu_res_t activation_of(afu_item_t it);
            longint   v, r;
            afu_res_t o;
            v = $signed(it.operand);
            // Products are rescaled with round to nearest, ties upward, which
            // is an arithmetic shift after adding half an LSB.
            case (it.opcode)
                OP_IDENT:  r = v;
                OP_DIDENT: r = ONE_Q;
                OP_SIGM:   r = sigmoid_q(v);
                OP_DSIGM:  r = (v * (ONE_Q - v) + HALF_Q) >>> FRAC_BITS;
                OP_TANH:   r = 2 * sigmoid_q(2 * v) - ONE_Q;
                OP_DTANH:  r = ONE_Q - ((v * v + HALF_Q) >>> FRAC_BITS);
                OP_RELU:   r = (v > 0) ? v : 0;
                default:   r = (v > 0) ? ONE_Q : 0;
            endcase
            o.saturated = 1'b0;
            if (r > 32767)
            begin
                r = 32767;
                o.saturated = 1'b1;
            end
            else if (r < -32768)
            begin
                r = -32768;
                o.saturated = 1'b1;
            end
            o.result = r[15:0];
            o.last_out = it.last_in;
            return o;
        endfunction

        function void note_item(afu_item_t it);
            pending_results.push_back(activation_of(it));
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void check_result(afu_res_t got);
            afu_res_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result item, actual %0d sat %0b last %0b",
                         $time, got.result, got.saturated, got.last_out);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.result !== want.result)
            begin
                $display("%0t: result mismatch, expected %0d actual %0d",
                         $time, want.result, got.result);
                errors++;
            end
            if (got.saturated !== want.saturated)
            begin
                $display("%0t: saturated mismatch, expected %0b actual %0b",
                         $time, want.saturated, got.saturated);
                errors++;
            end
            if (got.last_out !== want.last_out)
            begin
                $display("%0t: last_out mismatch, expected %0b actual %0b",
                         $time, want.last_out, got.last_out);
                errors++;
            end
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    afu_item_t item = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    afu_res_t  res;

    // Percentages of cycles in which the sender idles and the receiver
    // stalls; the main sequence changes them from phase to phase.
    int idle_pct = 0;
    int stall_pct = 0;
    // Remaining cycles of a forced receiver hold-off, counted down by the
    // receiver process itself.
    int hold_cycles = 0;
    int quiet_cycles = 0;

    activation_scoreboard sb;

    activation_function_unit_top #(
        .SEGMENTS(SEGMENTS),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Monitor. It runs at the rising edge before any nonblocking update has
    // landed, so it sees exactly the values that the handshake used.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                sb.note_item(item);
            if (res_valid && res_ready)
                sb.check_result(res);
        end
    end

    // Receiver. Outside a hold-off it stalls at random with the current
    // percentage; during a hold-off it keeps res_ready low throughout.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                res_ready <= 1'b0;
                hold_cycles--;
            end
            else
                res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (res_valid && res_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Offers one item and returns at the edge where it is accepted. Random
    // idle cycles go in front of the item; with no idle cycle, valid simply
    // stays high and only the payload changes.
    task automatic send_item(input afu_op_t op, input logic [15:0] val, input logic last);
        afu_item_t next_item;
        next_item.opcode = op;
        next_item.operand = val;
        next_item.last_in = last;
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= next_item;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // Random items. Operands are mixed: the full 16-bit range, values near
    // the unit interval where the derivatives do something useful, and
    // values on or next to a sigmoid breakpoint (a multiple of 2048).
    task automatic send_random_items(input int count);
        int unsigned raw;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(3))
                0: raw = $urandom_range(16384) - 8192;
                1: raw = $urandom_range(31) * 2048 + $urandom_range(2) - 1 - 32768;
                default: raw = $urandom_range(65535);
            endcase
            send_item(afu_op_t'($urandom_range(7)), raw[15:0], $urandom_range(7) == 0);
        end
    endtask

    // Drops valid and waits until every predicted result has been seen. The
    // first edge lets the monitor note an item accepted at the last edge.
    task automatic wait_for_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items: operand extremes for identity, sigmoid and its
        // derivative, sigmoid at a breakpoint and off it, tanh driven past both
        // ends of the table, and derivatives whose products leave the Q4.12 range.
        send_item(OP_IDENT, 16'h8000, 1'b0);
        send_item(OP_IDENT, 16'h7fff, 1'b1);
        send_item(OP_DIDENT, 16'h0000, 1'b0);
        send_item(OP_SIGM, 16'h8000, 1'b0);
        send_item(OP_SIGM, 16'h7fff, 1'b1);
        send_item(OP_SIGM, 16'h0000, 1'b0);
        send_item(OP_SIGM, 16'h8800, 1'b0);
        send_item(OP_SIGM, 16'h0001, 1'b1);
        send_item(OP_DSIGM, 16'h1000, 1'b0);
        send_item(OP_DSIGM, 16'h0800, 1'b0);
        send_item(OP_DSIGM, 16'h8000, 1'b0);
        send_item(OP_DSIGM, 16'h7fff, 1'b1);
        send_item(OP_TANH, 16'h4000, 1'b0);
        send_item(OP_TANH, 16'hbfff, 1'b0);
        send_item(OP_TANH, 16'hffff, 1'b1);
        send_item(OP_DTANH, 16'h8000, 1'b0);
        send_item(OP_DTANH, 16'h1000, 1'b0);
        send_item(OP_DTANH, 16'h0001, 1'b1);
        send_item(OP_RELU, 16'hffff, 1'b0);
        send_item(OP_RELU, 16'h7fff, 1'b1);
        send_item(OP_DRELU, 16'h0000, 1'b0);
        send_item(OP_DRELU, 16'h0001, 1'b0);
        send_item(OP_DRELU, 16'h8000, 1'b1);

        // Back-to-back traffic with no idling on either side.
        send_random_items(440);

        // The receiver holds off for a long stretch while the sender keeps
        // offering items, so the pipeline fills and item_ready falls.
        hold_cycles = HOLD_OFF_CYCLES;
        send_random_items(40);

        idle_pct = 50;
        stall_pct = 0;
        send_random_items(440);

        // The sender pauses until the pipeline has emptied completely.
        wait_for_results();

        idle_pct = 0;
        stall_pct = 50;
        send_random_items(440);

        idle_pct = 38;
        stall_pct = 38;
        send_random_items(440);

        // Let the last results drain, then allow a few more cycles so that
        // any spurious result item would still be caught.
        wait_for_results();
        repeat (8) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
